// ----- src/lis_pkg.sv -----
package lis_pkg;

  // Capacity of the tail table (entries).
  localparam int LIS_MAX_LEN = 1024;

  // Width of a sample and of the reported length.
  localparam int SAMPLE_W  = 32;
  localparam int LEN_OUT_W = 11;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// ----- src/lis_tail_mem.sv -----
module lis_tail_mem
  import lis_pkg::*;
#(
  parameter int DEPTH = LIS_MAX_LEN,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  sample_t       wr_data,
  input  logic [AW-1:0] rd_addr,
  output sample_t       rd_data
);

  sample_t mem [DEPTH];
  sample_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/longest_increasing_subsequence_length.sv -----
// Each accepted word runs a binary search over the table length it sees (zero after a
//   start flag, in which case the search is skipped), then an update step writes the table.
// A new word is taken only once the last one is through its update; the search issues
//   one tail-memory read per cycle through a single registered read port, the update
//   writes at most one entry, and a result still waiting holds the next word in that step.
// Reset (synchronous, active low) clears length, overflow flag and handshake state;
//   the tail memory is not cleared, since the search only compares against written entries.
module longest_increasing_subsequence_length
  import lis_pkg::*;
#(
  parameter int MAX_LEN = LIS_MAX_LEN
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SAMPLE_W-1:0]  in_sample_value,
  input  logic                 in_sequence_start,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LEN_OUT_W-1:0] out_subsequence_length,
  output logic                 out_capacity_overflow
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_WRITE  = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [LW-1:0]        lo_r, lo_nxt;
  logic [LW-1:0]        hi_r, hi_nxt;
  logic [LW-1:0]        mid_r, mid_nxt;
  sample_t              key_r, key_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [LEN_OUT_W-1:0] out_len_r, out_len_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  sample_t       mem_wr_data;
  sample_t       mem_rd_data;

  lis_tail_mem #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_tail_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mid_nxt[AW-1:0]),
    .rd_data (mem_rd_data)
  );

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    logic [LW-1:0] len_eff;
    logic [LW-1:0] lo_n;
    logic [LW-1:0] hi_n;
    logic [LW:0]   sum;
    state_nxt     = state_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    out_len_nxt   = out_len_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = lo_r[AW-1:0];
    mem_wr_data   = key_r;
    len_eff       = in_sequence_start ? '0 : len_r;
    lo_n          = lo_r;
    hi_n          = hi_r;
    sum           = '0;

    // drop the held word once it is taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt = sample_t'(in_sample_value);
          len_nxt = len_eff;
          if (in_sequence_start) begin
            ovf_nxt = 1'b0;
          end
          lo_nxt  = '0;
          hi_nxt  = len_eff;
          mid_nxt = len_eff >> 1;
          state_nxt = (len_eff != '0) ? ST_SEARCH : ST_WRITE;
        end
      end
      ST_SEARCH: begin
        // narrow to the first entry not below the key
        if (mem_rd_data >= key_r) begin
          hi_n = mid_r;
        end else begin
          lo_n = mid_r + 1'b1;
        end
        lo_nxt = lo_n;
        hi_nxt = hi_n;
        if (lo_n < hi_n) begin
          sum     = {1'b0, lo_n} + {1'b0, hi_n};
          mid_nxt = sum[LW:1];
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          if (lo_r == len_r) begin
            if (len_r < LW'(MAX_LEN)) begin
              mem_wr_en = 1'b1;
              len_nxt   = len_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            mem_wr_en = 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_len_nxt   = LEN_OUT_W'(len_nxt);
          out_ovf_nxt   = ovf_nxt;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    key_r     <= key_nxt;
    out_len_r <= out_len_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_subsequence_length = out_len_r;
  assign out_capacity_overflow  = out_ovf_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != ST_IDLE)
    else $error("accepted word did not start processing");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(MAX_LEN))
    else $error("table length beyond capacity");

  a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEARCH |-> mid_r >= lo_r && mid_r < hi_r)
    else $error("search probe outside its range");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> len_r == LW'(MAX_LEN))
    else $error("overflow flagged with table not full");

  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE && state_nxt == ST_IDLE |=> out_valid_r)
    else $error("update finished without a result");

endmodule

// ----- tb/sv/lis_checker.sv -----
`timescale 1ns / 1ps

module lis_checker
  import lis_pkg::*;
#(
  parameter int MAX_LEN = LIS_MAX_LEN
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [SAMPLE_W-1:0]  in_sample_value,
  input  logic                 in_sequence_start,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [LEN_OUT_W-1:0] out_subsequence_length,
  input  logic                 out_capacity_overflow,
  output int                   mismatch_count,
  output int                   results_pending
);

  typedef struct packed {
    logic [LEN_OUT_W-1:0] length;
    logic                 overflow;
  } lis_result_t;

  // Smallest end value of an increasing run of each length
  sample_t     tails [MAX_LEN];
  int          run_len = 0;
  logic        run_overflow = 1'b0;
  lis_result_t expected_lengths [$];
  int          errors = 0;

  function automatic lis_result_t next_lis_result(sample_t v, logic start);
    int          lo;
    int          hi;
    int          mid;
    lis_result_t r;
    if (start) begin
      run_len      = 0;
      run_overflow = 1'b0;
    end
    if (run_len == 0) begin
      tails[0] = v;
      run_len  = 1;
    end else if (v < tails[0]) begin
      tails[0] = v;
    end else if (v > tails[run_len-1]) begin
      if (run_len < MAX_LEN) begin
        tails[run_len] = v;
        run_len++;
      end else begin
        run_overflow = 1'b1;
      end
    end else begin
      // first tail not below v
      lo = 0;
      hi = run_len - 1;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (tails[mid] >= v) hi = mid;
        else lo = mid + 1;
      end
      tails[lo] = v;
    end
    r.length   = run_len[LEN_OUT_W-1:0];
    r.overflow = run_overflow;
    return r;
  endfunction

  always @(posedge clk) begin
    lis_result_t exp_res;
    if (!rst_n) begin
      run_len      = 0;
      run_overflow = 1'b0;
      expected_lengths.delete();
    end else begin
      // results leave in order, so compare before queueing this edge's word
      if (out_valid && out_ready) begin
        if (expected_lengths.size() == 0) begin
          $error("unexpected result: subsequence_length=%0d capacity_overflow=%0b",
                 out_subsequence_length, out_capacity_overflow);
          errors++;
        end else begin
          exp_res = expected_lengths.pop_front();
          if (out_subsequence_length !== exp_res.length) begin
            $error("subsequence_length: expected %0d, actual %0d",
                   exp_res.length, out_subsequence_length);
            errors++;
          end
          if (out_capacity_overflow !== exp_res.overflow) begin
            $error("capacity_overflow: expected %0b, actual %0b",
                   exp_res.overflow, out_capacity_overflow);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_lengths.insert(expected_lengths.size(),
                                next_lis_result(in_sample_value, in_sequence_start));
    end
    mismatch_count  <= errors;
    results_pending <= expected_lengths.size();
  end

endmodule

// ----- tb/sv/tb_longest_increasing_subsequence_length.sv -----
`timescale 1ns / 1ps

module tb_longest_increasing_subsequence_length
  import lis_pkg::*;
;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int WORD_TARGET    = 800;
  localparam int HOLD_AFTER     = 150;
  localparam int FULL_RUN_AFTER = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 30;
  localparam int FULL_RUN_WORDS = LIS_MAX_LEN + 6;

  localparam sample_t S_MIN = 32'sh8000_0000;
  localparam sample_t S_MAX = 32'sh7fff_ffff;

  typedef enum int {
    SEQ_SPREAD,
    SEQ_NARROW,
    SEQ_RISING,
    SEQ_EXTREME
  } seq_style_e;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  in_sample_value;
  logic                 in_sequence_start;
  logic                 out_valid;
  logic                 out_ready;
  logic [LEN_OUT_W-1:0] out_subsequence_length;
  logic                 out_capacity_overflow;

  int mismatch_count;
  int results_pending;
  int cycle_count = 0;
  int words_sent;
  bit idle_on;

  longest_increasing_subsequence_length #(
    .MAX_LEN(LIS_MAX_LEN)
  ) i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_sample_value       (in_sample_value),
    .in_sequence_start     (in_sequence_start),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_subsequence_length(out_subsequence_length),
    .out_capacity_overflow (out_capacity_overflow)
  );

  lis_checker #(
    .MAX_LEN(LIS_MAX_LEN)
  ) i_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_sample_value       (in_sample_value),
    .in_sequence_start     (in_sequence_start),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_subsequence_length(out_subsequence_length),
    .out_capacity_overflow (out_capacity_overflow),
    .mismatch_count        (mismatch_count),
    .results_pending       (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_longest_increasing_subsequence_length: FAIL");
      $finish;
    end
  end

  // Lower valid only when a gap follows, so it never drops and rises in one step
  task automatic send_word(sample_t v, logic start);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_sample_value   <= v;
    in_sequence_start <= start;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  function automatic sample_t extreme_value();
    case ($urandom_range(0, 5))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4:       return S_MIN + 1;
      default: return S_MAX - 1;
    endcase
  endfunction

  task automatic send_sequence(int count, seq_style_e style, bit with_start);
    sample_t base;
    sample_t v;
    base = $urandom;
    for (int i = 0; i < count; i++) begin
      case (style)
        SEQ_SPREAD: v = $urandom;
        SEQ_NARROW: begin
          v = $urandom_range(0, 15);
          v = v - 8;
        end
        SEQ_RISING: begin
          // mostly climb, sometimes dip back to force a table replace
          if ($urandom_range(0, 4) == 0) begin
            v = base - sample_t'($urandom_range(0, 60));
          end else begin
            base = base + sample_t'($urandom_range(0, 3));
            v    = base;
          end
        end
        default: v = extreme_value();
      endcase
      send_word(v, with_start && (i == 0));
    end
  endtask

  // Fill the table, push past capacity, replace inside the full table, then push past it again
  task automatic send_full_run();
    sample_t v;
    v = S_MIN;
    for (int i = 0; i < FULL_RUN_WORDS; i++) begin
      send_word(v, i == 0);
      v = v + 32'sd4000000;
    end
    send_word(32'sd12345, 1'b0);
    send_word(S_MIN, 1'b0);
    send_word(S_MAX, 1'b0);
    send_word(S_MAX, 1'b0);
  endtask

  initial begin
    int gap;
    bit hold_done;
    out_ready = 1'b0;
    hold_done = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_done && words_sent > HOLD_AFTER) begin
        // stall the output long enough for the input to back up
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    seq_style_e style;
    bit full_run_done;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_sample_value   <= '0;
    in_sequence_start <= 1'b0;
    idle_on       = 1'b1;
    full_run_done = 1'b0;
    words_sent    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first word lands in an empty table without a start flag
    send_word(32'sd5, 1'b0);
    send_word(32'sd5, 1'b0);
    send_word(32'sd3, 1'b0);
    send_word(32'sd10, 1'b0);
    send_word(S_MAX, 1'b0);
    send_word(32'sd7, 1'b0);
    send_word(32'sd4, 1'b0);
    send_word(S_MIN, 1'b0);
    send_word(S_MAX, 1'b0);
    send_word(32'sd10, 1'b0);
    send_word(S_MAX, 1'b1);
    send_word(S_MIN, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(32'sd0, 1'b0);
    send_word(32'sd1, 1'b0);
    send_word(32'sd0, 1'b0);
    send_word(-32'sd1, 1'b1);
    send_word(-32'sd1, 1'b1);
    send_word(S_MIN + 1, 1'b0);
    send_word(S_MAX - 1, 1'b0);
    send_word(32'sd0, 1'b0);

    idle_on = 1'b0;
    send_word(32'sd1, 1'b1);
    send_word(32'sd2, 1'b0);
    send_word(32'sd3, 1'b0);

    while (words_sent < WORD_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (!full_run_done && words_sent > FULL_RUN_AFTER) begin
        send_full_run();
        full_run_done = 1'b1;
      end
      style = seq_style_e'($urandom_range(0, 3));
      // on average half of the sequences are rising runs that grow the table
      if ($urandom_range(0, 2) == 0) style = SEQ_RISING;
      send_sequence($urandom_range(1, 40), style, $urandom_range(0, 7) != 0);
    end

    @(posedge clk);
    in_valid <= 1'b0;
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_longest_increasing_subsequence_length: PASS");
    else
      $display("tb_longest_increasing_subsequence_length: FAIL");
    $finish;
  end

endmodule
